// ===== rtl/exception_deadband_reporter_top_defines.svh =====
// ----------------------------------------------------------------------------
// exception_deadband_reporter_top_defines
// Assertion macros for the exception deadband reporter.
// The enclosing module provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef EXCEPTION_DEADBAND_REPORTER_TOP_DEFINES_SVH
`define EXCEPTION_DEADBAND_REPORTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define EDR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define EDR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define EDR_ASSERT_IMP(lbl, ante, cons)

`define EDR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/edr_pkg.sv =====
// ----------------------------------------------------------------------------
// edr_pkg
// Shared types and constants of the exception deadband reporter.
// ----------------------------------------------------------------------------
package edr_pkg;

  localparam int NUM_POINTS_DEF = 1024;
  localparam int QUEUE_DEPTH    = 2;
  localparam int PT_W           = 10;
  localparam int VAL_W          = 32;
  localparam int DEV_W          = 31;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [1:0] STAT_INVALID = 2'd0;
  localparam logic [1:0] STAT_GOOD    = 2'd1;
  localparam logic [1:0] STAT_ON      = 2'd2;

  typedef struct packed {
    logic                    is_sample;
    logic [PT_W-1:0]         point;
    logic                    is_real;
    logic [VAL_W-1:0]        min_iv;
    logic [VAL_W-1:0]        max_iv;
    logic [DEV_W-1:0]        dev;
    logic signed [VAL_W-1:0] value;
    logic                    valid;
    logic [VAL_W-1:0]        now;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/edr_front.sv =====
// ----------------------------------------------------------------------------
// edr_front
// Accepts requests, drops out-of-range points, packs items for the queue.
// ----------------------------------------------------------------------------
module edr_front #(
  parameter int NUM_POINTS = edr_pkg::NUM_POINTS_DEF
) (
  input  logic                            push,
  output logic                            full,
  input  logic                            mode,
  input  logic [edr_pkg::PT_W-1:0]        point_index,
  input  logic                            is_real,
  input  logic [edr_pkg::VAL_W-1:0]       min_interval,
  input  logic [edr_pkg::VAL_W-1:0]       max_interval,
  input  logic [edr_pkg::DEV_W-1:0]       deviation,
  input  logic signed [edr_pkg::VAL_W-1:0] sample_value,
  input  logic                            sample_valid,
  input  logic [edr_pkg::VAL_W-1:0]       now_time,
  input  edr_pkg::q_stat_t                q_stat,
  output logic                            q_push,
  output edr_pkg::item_t                  q_item
);
  import edr_pkg::*;

  logic in_range;

  assign full     = q_stat.full;
  assign in_range = 32'(point_index) < 32'(NUM_POINTS);
  assign q_push   = push && !q_stat.full && in_range;

  always_comb begin
    q_item.is_sample = (mode == MODE_SAMPLE);
    q_item.point     = point_index;
    q_item.is_real   = is_real;
    q_item.min_iv    = min_interval;
    q_item.max_iv    = max_interval;
    q_item.dev       = deviation;
    q_item.value     = sample_value;
    q_item.valid     = sample_valid;
    q_item.now       = now_time;
  end

endmodule

// ===== rtl/edr_queue.sv =====
// ----------------------------------------------------------------------------
// edr_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module edr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  edr_pkg::item_t   wr_item,
  input  logic             rd,
  output edr_pkg::item_t   rd_item,
  output edr_pkg::q_stat_t stat
);
  import edr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign rd_item    = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/edr_back.sv =====
// ----------------------------------------------------------------------------
// edr_back
// Point table, report decision and result register.
// ----------------------------------------------------------------------------
module edr_back #(
  parameter int NUM_POINTS = edr_pkg::NUM_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  edr_pkg::q_stat_t                 q_stat,
  input  edr_pkg::item_t                   q_item,
  output logic                             q_pop,
  input  logic                             pop,
  output logic                             empty,
  output logic [edr_pkg::PT_W-1:0]         report_point,
  output logic signed [edr_pkg::VAL_W-1:0] report_value,
  output logic [1:0]                       report_status
);
  import edr_pkg::*;

  localparam int ADDR_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  typedef struct packed {
    logic             kind_real;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [DEV_W-1:0] dev;
    logic [VAL_W-1:0] lval;
    logic             lvalid;
    logic [VAL_W-1:0] ltime;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EV1,
    S_EV2,
    S_DEC
  } state_t;

  entry_t            mem [NUM_POINTS];
  entry_t            rd_data;
  state_t            state;
  item_t             cur;
  logic              out_valid;
  logic [VAL_W-1:0]  elapsed;
  logic signed [VAL_W:0] diff;
  logic [VAL_W:0]    mag;
  logic              lt_low;
  logic              ge_high;
  logic              dig_diff;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  entry_t            mem_wdata;
  logic [31:0]       pt_ext;
  logic              report;
  logic              out_free;
  logic [1:0]        status;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign q_pop    = (state == S_IDLE) && !q_stat.empty;
  assign pt_ext   = (state == S_IDLE) ? 32'(q_item.point) : 32'(cur.point);
  assign mem_addr = pt_ext[ADDR_W-1:0];

  assign report = !lt_low && (ge_high || (cur.valid != rd_data.lvalid) ||
                  (cur.valid && (rd_data.kind_real ? (mag >= {2'b00, rd_data.dev})
                                                   : dig_diff)));

  always_comb begin
    if (!cur.valid) begin
      status = STAT_INVALID;
    end else if (rd_data.kind_real) begin
      status = STAT_GOOD;
    end else begin
      status = (cur.value != '0) ? STAT_ON : STAT_GOOD;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_data;
    if (state == S_IDLE && !q_stat.empty && !q_item.is_sample) begin
      mem_we           = 1'b1;
      mem_wdata.kind_real = q_item.is_real;
      mem_wdata.lo     = q_item.min_iv;
      mem_wdata.hi     = q_item.max_iv;
      mem_wdata.dev    = q_item.dev;
      mem_wdata.lval   = '0;
      mem_wdata.lvalid = 1'b0;
      mem_wdata.ltime  = '0;
    end else if (state == S_DEC && report && out_free) begin
      mem_we           = 1'b1;
      mem_wdata.lval   = cur.value;
      mem_wdata.lvalid = cur.valid;
      mem_wdata.ltime  = cur.now;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && !(state == S_DEC && report)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cur <= q_item;
            if (q_item.is_sample) begin
              state <= S_EV1;
            end
          end
        end
        S_EV1: begin
          elapsed <= cur.now - rd_data.ltime;
          diff    <= {cur.value[VAL_W-1], cur.value} -
                     $signed({rd_data.lval[VAL_W-1], rd_data.lval});
          state   <= S_EV2;
        end
        S_EV2: begin
          lt_low   <= elapsed < rd_data.lo;
          ge_high  <= elapsed >= rd_data.hi;
          mag      <= diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
          dig_diff <= cur.value != rd_data.lval;
          state    <= S_DEC;
        end
        S_DEC: begin
          if (!report) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid     <= 1'b1;
            report_point  <= cur.point;
            report_value  <= cur.value;
            report_status <= status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/exception_deadband_reporter_top.sv =====
// A sample is read from the single-port point table in S_IDLE, evaluated
// in S_EV1 and S_EV2 and decided in S_DEC, where a report is written back
// once the result register is free; loads go one per cycle while idle.
// Reset clears the queue, sequencer and result register; the point table
// is not cleared and each point must be loaded before it is sampled.
// ----------------------------------------------------------------------------
// exception_deadband_reporter_top
// Per-point exception reporting filter with min/max interval and deadband.
// ----------------------------------------------------------------------------
`include "exception_deadband_reporter_top_defines.svh"

module exception_deadband_reporter_top #(
  parameter int NUM_POINTS = edr_pkg::NUM_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             mode,
  input  logic [edr_pkg::PT_W-1:0]         point_index,
  input  logic                             is_real,
  input  logic [edr_pkg::VAL_W-1:0]        min_interval,
  input  logic [edr_pkg::VAL_W-1:0]        max_interval,
  input  logic [edr_pkg::DEV_W-1:0]        deviation,
  input  logic signed [edr_pkg::VAL_W-1:0] sample_value,
  input  logic                             sample_valid,
  input  logic [edr_pkg::VAL_W-1:0]        now_time,
  output logic                             empty,
  input  logic                             pop,
  output logic [edr_pkg::PT_W-1:0]         report_point,
  output logic signed [edr_pkg::VAL_W-1:0] report_value,
  output logic [1:0]                       report_status
);
  import edr_pkg::*;

  q_stat_t q_stat;
  item_t   wr_item;
  item_t   rd_item;
  logic    q_push;
  logic    q_pop;

  edr_front #(.NUM_POINTS(NUM_POINTS)) u_front (
    .push         (push),
    .full         (full),
    .mode         (mode),
    .point_index  (point_index),
    .is_real      (is_real),
    .min_interval (min_interval),
    .max_interval (max_interval),
    .deviation    (deviation),
    .sample_value (sample_value),
    .sample_valid (sample_valid),
    .now_time     (now_time),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_item       (wr_item)
  );

  edr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_item (wr_item),
    .rd      (q_pop),
    .rd_item (rd_item),
    .stat    (q_stat)
  );

  edr_back #(.NUM_POINTS(NUM_POINTS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .q_item        (rd_item),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .report_point  (report_point),
    .report_value  (report_value),
    .report_status (report_status)
  );

  `EDR_ASSERT_IMP(a_push_not_full, q_push, !q_stat.full)
  `EDR_ASSERT_IMP(a_pop_not_empty, q_pop, !q_stat.empty)
  `EDR_ASSERT_IMP(a_full_not_empty, q_stat.full, !q_stat.empty)
  `EDR_ASSERT_NXT(a_result_kept, !empty && !pop, !empty)

endmodule

// ===== verif/exception_deadband_reporter_top_tb.sv =====
// ----------------------------------------------------------------------------
// exception_deadband_reporter_top_tb
// Self-checking bench for the exception deadband reporter. A short table of
// directed requests covers interval limits, deadband edges, validity changes,
// time wrap and reloads. It is followed by about a thousand random loads and
// samples on a pool of loaded points. Every accepted request runs through a
// local point-table predictor. Each popped report is checked against the
// oldest expected one. Random gaps on push and pop, one long pop hold-off and
// one drain pause stress the handshakes.
// ----------------------------------------------------------------------------
module exception_deadband_reporter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edr_pkg::*;

  localparam int NPTS        = NUM_POINTS_DEF;
  localparam int RAND_REQS   = 1020;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [PT_W-1:0]         point;
    logic signed [VAL_W-1:0] value;
    logic [1:0]              status;
  } report_t;

  typedef struct {
    item_t      req;
    bit         typed;
    bit         typed_rep;
    logic [1:0] typed_status;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  logic mode;
  logic [PT_W-1:0] point_index;
  logic is_real;
  logic [VAL_W-1:0] min_interval;
  logic [VAL_W-1:0] max_interval;
  logic [DEV_W-1:0] deviation;
  logic signed [VAL_W-1:0] sample_value;
  logic sample_valid;
  logic [VAL_W-1:0] now_time;
  logic empty;
  logic pop;
  logic [PT_W-1:0] report_point;
  logic signed [VAL_W-1:0] report_value;
  logic [1:0] report_status;

  exception_deadband_reporter_top uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .point_index(point_index), .is_real(is_real), .min_interval(min_interval),
    .max_interval(max_interval), .deviation(deviation), .sample_value(sample_value),
    .sample_valid(sample_valid), .now_time(now_time), .empty(empty), .pop(pop),
    .report_point(report_point), .report_value(report_value),
    .report_status(report_status)
  );

  always #6ns clk = ~clk;

  // local copy of the point table
  bit                      pt_real   [NPTS];
  logic [VAL_W-1:0]        pt_min    [NPTS];
  logic [VAL_W-1:0]        pt_max    [NPTS];
  logic [DEV_W-1:0]        pt_band   [NPTS];
  logic signed [VAL_W-1:0] pt_value  [NPTS];
  bit                      pt_valid  [NPTS];
  logic [VAL_W-1:0]        pt_time   [NPTS];
  bit                      pt_loaded [NPTS];

  report_t pending_reports[$];
  row_t    directed_rows[$];
  int      live_points[$];

  int errors = 0;
  int n_loads = 0;
  int n_samples = 0;
  int n_reports = 0;
  int stall_cycles = 0;
  int send_gap_pct = 0;
  int pop_gap_pct = 0;
  bit quiet = 1'b0;
  bit hold_pop = 1'b0;
  logic [VAL_W-1:0] tick = '0;

  task automatic predict_report(input item_t r, output bit rep, output report_t res);
    int p;
    logic [VAL_W-1:0] elapsed;
    longint diff;
    p = int'(r.point);
    rep = 1'b0;
    res = '{default: '0};
    if (r.is_sample == MODE_LOAD) begin
      pt_real[p]  = r.is_real;
      pt_min[p]   = r.min_iv;
      pt_max[p]   = r.max_iv;
      pt_band[p]  = r.dev;
      pt_value[p] = '0;
      pt_valid[p] = 1'b0;
      pt_time[p]  = '0;
      return;
    end
    elapsed = r.now - pt_time[p];
    if (elapsed < pt_min[p]) rep = 1'b0;
    else if (elapsed >= pt_max[p]) rep = 1'b1;
    else if (r.valid != pt_valid[p]) rep = 1'b1;
    else if (!r.valid) rep = 1'b0;
    else if (pt_real[p]) begin
      diff = longint'($signed(r.value)) - longint'(pt_value[p]);
      if (diff < 0) diff = -diff;
      rep = diff >= longint'({1'b0, pt_band[p]});
    end else rep = r.value != pt_value[p];
    if (!rep) return;
    pt_value[p] = r.value;
    pt_valid[p] = r.valid;
    pt_time[p]  = r.now;
    res.point = r.point;
    res.value = r.value;
    if (!r.valid) res.status = STAT_INVALID;
    else if (pt_real[p]) res.status = STAT_GOOD;
    else res.status = (r.value != '0) ? STAT_ON : STAT_GOOD;
  endtask

  task automatic send_req(input item_t r, input bit typed, input bit t_rep,
                          input logic [1:0] t_stat);
    bit rep;
    report_t res;
    @(negedge clk);
    if (!quiet && send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    mode         <= r.is_sample;
    point_index  <= r.point;
    is_real      <= r.is_real;
    min_interval <= r.min_iv;
    max_interval <= r.max_iv;
    deviation    <= r.dev;
    sample_value <= r.value;
    sample_valid <= r.valid;
    now_time     <= r.now;
    push         <= 1'b1;
    do @(posedge clk); while (full);
    predict_report(r, rep, res);
    if (typed) begin
      rep = t_rep;
      res.point = r.point;
      res.value = r.value;
      res.status = t_stat;
    end
    if (rep) pending_reports.push_back(res);
    if (r.is_sample == MODE_LOAD) begin
      n_loads++;
      if (!pt_loaded[r.point]) live_points.push_back(int'(r.point));
      pt_loaded[r.point] = 1'b1;
    end else n_samples++;
  endtask

  function automatic item_t noise_item();
    item_t r;
    r.is_sample = 1'($urandom_range(0, 1));
    r.point     = PT_W'($urandom());
    r.is_real   = 1'($urandom_range(0, 1));
    r.min_iv    = $urandom();
    r.max_iv    = $urandom();
    r.dev       = DEV_W'($urandom());
    r.value     = $urandom();
    r.valid     = 1'($urandom_range(0, 1));
    r.now       = $urandom();
    return r;
  endfunction

  function automatic void load_row(int pt, bit kind, logic [VAL_W-1:0] lo,
                                   logic [VAL_W-1:0] hi, logic [DEV_W-1:0] band);
    row_t row;
    row.req = noise_item();
    row.req.is_sample = MODE_LOAD;
    row.req.point = PT_W'(pt);
    row.req.is_real = kind;
    row.req.min_iv = lo;
    row.req.max_iv = hi;
    row.req.dev = band;
    row.typed = 1'b1;
    row.typed_rep = 1'b0;
    row.typed_status = STAT_INVALID;
    directed_rows.push_back(row);
  endfunction

  function automatic void sample_row(int pt, logic [VAL_W-1:0] val, bit vld,
                                     logic [VAL_W-1:0] t, bit typed, bit rep,
                                     logic [1:0] stat);
    row_t row;
    row.req = noise_item();
    row.req.is_sample = MODE_SAMPLE;
    row.req.point = PT_W'(pt);
    row.req.value = val;
    row.req.valid = vld;
    row.req.now = t;
    row.typed = typed;
    row.typed_rep = rep;
    row.typed_status = stat;
    directed_rows.push_back(row);
  endfunction

  function automatic item_t rand_load(int pt);
    item_t r;
    int pick;
    r = noise_item();
    r.is_sample = MODE_LOAD;
    r.point = PT_W'(pt);
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      r.min_iv = $urandom_range(0, 8);
      r.max_iv = r.min_iv + $urandom_range(5, 60);
    end else if (pick < 17) begin
      r.min_iv = '0;
      r.max_iv = '0;
    end
    if ($urandom_range(0, 9) < 7) r.dev = DEV_W'($urandom_range(0, 32'h30000));
    return r;
  endfunction

  function automatic item_t rand_sample(int pt);
    item_t r;
    int unsigned span;
    int unsigned delta;
    r = noise_item();
    r.is_sample = MODE_SAMPLE;
    r.point = PT_W'(pt);
    r.valid = $urandom_range(0, 99) < 85;
    case ($urandom_range(0, 19))
      0:       tick = $urandom();
      1, 2, 3, 4, 5: tick = tick + $urandom_range(10, 100);
      default: tick = tick + $urandom_range(0, 10);
    endcase
    r.now = tick;
    if (pt_real[pt]) begin
      span = (pt_band[pt] <= 31'h20000) ? 2 * int'(pt_band[pt]) + 1 : 32'h40000;
      delta = $urandom_range(0, span);
      if ($urandom_range(0, 2) != 0)
        r.value = $urandom_range(0, 1) ? pt_value[pt] + delta : pt_value[pt] - delta;
    end else begin
      case ($urandom_range(0, 3))
        0: r.value = '0;
        1: r.value = 1;
        2: r.value = pt_value[pt];
        default: ;
      endcase
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    report_t want;
    if (!rst && push && full) stall_cycles++;
    if (!rst && pop && !empty) begin
      n_reports++;
      if (pending_reports.size() == 0) begin
        $error("unexpected report: point %0d value %0d status %0d",
               report_point, report_value, report_status);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (report_point !== want.point) begin
          $error("report_point: expected %0d, got %0d", want.point, report_point);
          errors++;
        end
        if (report_value !== want.value) begin
          $error("report_value: expected %0d, got %0d", want.value, report_value);
          errors++;
        end
        if (report_status !== want.status) begin
          $error("report_status: expected %0d, got %0d", want.status, report_status);
          errors++;
        end
      end
    end
  end

  // receiver
  initial begin
    int n;
    int cyc;
    pop <= 1'b0;
    cyc = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) pop_gap_pct = $urandom_range(0, 1) ? 25 : 0;
      if (hold_pop) begin
        hold_pop = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && pop_gap_pct != 0 && $urandom_range(0, 99) < pop_gap_pct) begin
        pop <= 1'b0;
        n = $urandom_range(1, 5);
        repeat (n - 1) @(negedge clk);
      end else pop <= 1'b1;
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int pt;
    int pick;
    item_t r;
    rst          <= 1'b1;
    push         <= 1'b0;
    mode         <= MODE_LOAD;
    point_index  <= '0;
    is_real      <= 1'b0;
    min_interval <= '0;
    max_interval <= '0;
    deviation    <= '0;
    sample_value <= '0;
    sample_valid <= 1'b0;
    now_time     <= '0;

    // digital point, wide window
    load_row(0, 1'b0, 32'd0, 32'hFFFF_FFFF, 31'd0);
    sample_row(0, 32'd0, 1'b0, 32'd0, 1'b1, 1'b0, STAT_INVALID);
    sample_row(0, 32'd5, 1'b1, 32'd1, 1'b1, 1'b1, STAT_ON);
    sample_row(0, 32'd5, 1'b1, 32'd2, 1'b1, 1'b0, STAT_INVALID);
    sample_row(0, 32'd0, 1'b1, 32'd3, 1'b1, 1'b1, STAT_GOOD);
    sample_row(0, 32'h8000_0000, 1'b0, 32'd4, 1'b1, 1'b1, STAT_INVALID);
    // real point at top index, full deadband
    load_row(1023, 1'b1, 32'd10, 32'd100, 31'h7FFF_FFFF);
    sample_row(1023, 32'h7FFF_FFFF, 1'b1, 32'd5, 1'b1, 1'b0, STAT_INVALID);
    sample_row(1023, 32'h7FFF_FFFF, 1'b1, 32'd10, 1'b1, 1'b1, STAT_GOOD);
    sample_row(1023, 32'h8000_0000, 1'b1, 32'd20, 1'b0, 1'b0, STAT_INVALID);
    sample_row(1023, 32'h8000_0001, 1'b1, 32'd30, 1'b0, 1'b0, STAT_INVALID);
    sample_row(1023, 32'h8000_0001, 1'b1, 32'd130, 1'b0, 1'b0, STAT_INVALID);
    sample_row(1023, 32'd0, 1'b1, 32'd129, 1'b0, 1'b0, STAT_INVALID);
    // minimum above maximum
    load_row(5, 1'b1, 32'd50, 32'd20, 31'h1_0000);
    sample_row(5, 32'h1_0000, 1'b1, 32'd30, 1'b0, 1'b0, STAT_INVALID);
    sample_row(5, 32'h1_0000, 1'b1, 32'd50, 1'b0, 1'b0, STAT_INVALID);
    // deadband edge
    load_row(512, 1'b1, 32'd0, 32'hFFFF_FFFF, 31'h1_0000);
    sample_row(512, 32'h1_0000, 1'b1, 32'd7, 1'b0, 1'b0, STAT_INVALID);
    sample_row(512, 32'h1_FFFF, 1'b1, 32'd8, 1'b0, 1'b0, STAT_INVALID);
    sample_row(512, 32'h2_0000, 1'b1, 32'd9, 1'b0, 1'b0, STAT_INVALID);
    sample_row(512, -32'sd5, 1'b0, 32'd10, 1'b0, 1'b0, STAT_INVALID);
    // all-ones intervals
    load_row(341, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    sample_row(341, 32'd1, 1'b1, 32'hFFFF_FFFE, 1'b0, 1'b0, STAT_INVALID);
    sample_row(341, 32'd1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, STAT_ON);
    // reload clears the snapshot, zero max forces every report
    load_row(0, 1'b0, 32'd0, 32'd0, 31'd0);
    sample_row(0, 32'd0, 1'b0, 32'h2AAA_AAAA, 1'b1, 1'b1, STAT_INVALID);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].typed,
               directed_rows[i].typed_rep, directed_rows[i].typed_status);

    repeat (20) send_req(rand_load($urandom_range(0, NPTS - 1)), 1'b0, 1'b0, STAT_INVALID);

    for (int i = 0; i < RAND_REQS; i++) begin
      if (i % 100 == 0) send_gap_pct = $urandom_range(0, 1) ? 25 : 0;
      if (i == 300) hold_pop = 1'b1;
      if (i == 600) begin
        @(negedge clk);
        push <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
      end
      if (i == RAND_REQS - 150) quiet = 1'b1;
      pt = live_points[$urandom_range(0, live_points.size() - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 85) r = rand_sample(pt);
      else if (pick < 90) r = rand_load(pt);
      else if (pick < 95) r = rand_load($urandom_range(0, NPTS - 1));
      else begin
        r = noise_item();
        r.is_sample = MODE_SAMPLE;
        r.point = PT_W'(pt);
        tick = r.now;
      end
      send_req(r, 1'b0, 1'b0, STAT_INVALID);
    end

    @(negedge clk);
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d loads and %0d samples over %0d points; %0d reports checked",
             n_loads, n_samples, live_points.size(), n_reports);
    $display("input held off by full on %0d cycles", stall_cycles);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
